[design/dfr_pkg.sv]
package dfr_pkg;

  localparam logic [15:0] HeaderBytes = 16'd3;
  localparam logic [15:0] MaxLenReset = 16'd4096;
  localparam logic [15:0] WordBytes   = 16'd8;
  // ping/pong payload needed for a complete report: stamp word plus sequence word
  localparam logic [15:0] CtrlBytes   = WordBytes << 1;

  localparam logic [7:0] TypeData = 8'd0;
  localparam logic [7:0] TypePing = 8'd1;
  localparam logic [7:0] TypePong = 8'd2;

  typedef enum logic [2:0] {
    KindData    = 3'd0,
    KindPing    = 3'd1,
    KindPong    = 3'd2,
    KindUnknown = 3'd3,
    KindBadLen  = 3'd4,
    KindShort   = 3'd5,
    KindEmpty   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] stamp;
    logic [63:0] sequence_res;
  } dfr_res_t;

endpackage

[design/dfr_if.sv]
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic                valid;
  logic                ready;
  dfr_pkg::kind_e      kind;
  logic [7:0]          payload_byte;
  logic                last;
  logic [63:0]         stamp;
  logic [63:0]         sequence_res;

  modport source (output valid, output kind, output payload_byte, output last,
                  output stamp, output sequence_res, input ready);
  modport sink (input valid, input kind, input payload_byte, input last,
                input stamp, input sequence_res, output ready);
endinterface

[design/length_prefixed_frame_deframer_core.sv]
// channel   dir  modport  payload
// rx_i      in   sink     rx_byte[7:0]
// res_o     out  source   kind[2:0] payload_byte[7:0] last stamp[63:0] sequence_res[63:0]
// cfg       in   wr only  cfg_we_i, cfg_wdata_i[15:0] = max_frame_length
//
// one byte per cycle sustained while res_o is not stalled; a beat goes input register ->
// parser -> result register, the parser itself being combinational
// rst_ni clears parser state, both valid flags and sets max_frame_length to 4096
// a stalled result holds the result register; an empty input register still takes one
// more byte, then rx_i.ready drops until the result is taken
module length_prefixed_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfr_in_if.sink      rx_i,
  dfr_out_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import dfr_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        step;
  logic        rx_fire;
  logic [15:0] max_len_q;
  logic        p_valid;
  dfr_res_t    p_res;
  logic        res_valid_q;
  dfr_res_t    res_q;

  assign step       = in_valid_q && (!res_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || step;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  dfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .max_len_i   (max_len_q),
    .res_valid_o (p_valid),
    .res_o       (p_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= p_valid;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && p_valid) begin
      res_q <= p_res;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.payload_byte = res_q.payload_byte;
  assign res_o.last         = res_q.last;
  assign res_o.stamp        = res_q.stamp;
  assign res_o.sequence_res = res_q.sequence_res;

endmodule

[design/dfr_parser.sv]
module dfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       max_len_i,
  output logic              res_valid_o,
  output dfr_pkg::dfr_res_t res_o
);
  import dfr_pkg::*;

  typedef enum logic [3:0] {
    PhLenHi = 4'b0001,
    PhLenLo = 4'b0010,
    PhType  = 4'b0100,
    PhBody  = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] stamp_q, stamp_d;
  logic [63:0] seq_q, seq_d;
  logic        skip_q, skip_d;

  logic [15:0] len_full;
  logic [15:0] offset;
  logic [15:0] seen_inc;
  logic        frame_end;
  logic        is_ctrl;

  function automatic dfr_res_t finish_other(logic [7:0] ftype, logic [15:0] flen,
                                            logic [63:0] st, logic [63:0] sq);
    dfr_res_t r;
    r = '0;
    if (ftype == TypePing || ftype == TypePong) begin
      if ((flen - HeaderBytes) >= CtrlBytes) begin
        r.kind         = (ftype == TypePing) ? KindPing : KindPong;
        r.stamp        = st;
        r.sequence_res = sq;
      end else begin
        r.kind = KindShort;
      end
    end else begin
      r.kind = KindUnknown;
    end
    return r;
  endfunction

  assign len_full  = {len_q[15:8], byte_i};
  assign offset    = seen_q - HeaderBytes;
  assign seen_inc  = seen_q + 16'd1;
  assign frame_end = (seen_inc >= len_q);
  assign is_ctrl   = (type_q == TypePing) || (type_q == TypePong);

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    seen_d      = seen_q;
    type_d      = type_q;
    stamp_d     = stamp_q;
    seq_d       = seq_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PhLenHi: begin
        len_d   = {byte_i, 8'h00};
        seen_d  = 16'd1;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d  = len_full;
        seen_d = 16'd2;
        if (len_full < HeaderBytes) begin
          // resync: next byte starts a new length
          phase_d     = PhLenHi;
          seen_d      = 16'd0;
          res_valid_o = 1'b1;
          res_o.kind  = KindBadLen;
        end else if (len_full > max_len_i) begin
          skip_d      = 1'b1;
          phase_d     = PhBody;
          res_valid_o = 1'b1;
          res_o.kind  = KindBadLen;
        end else begin
          skip_d  = 1'b0;
          phase_d = PhType;
        end
      end
      PhType: begin
        type_d  = byte_i;
        seen_d  = HeaderBytes;
        stamp_d = '0;
        seq_d   = '0;
        if (len_q == HeaderBytes) begin
          phase_d     = PhLenHi;
          res_valid_o = 1'b1;
          if (byte_i == TypeData) begin
            res_o.kind = KindEmpty;
          end else begin
            res_o = finish_other(byte_i, len_q, 64'd0, 64'd0);
          end
        end else begin
          phase_d = PhBody;
        end
      end
      PhBody: begin
        seen_d = seen_inc;
        if (frame_end) begin
          phase_d = PhLenHi;
        end
        if (skip_q) begin
          if (frame_end) begin
            skip_d = 1'b0;
          end
        end else if (type_q == TypeData) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KindData;
          res_o.payload_byte = byte_i;
          res_o.last         = frame_end;
        end else begin
          if (is_ctrl) begin
            if (offset < WordBytes) begin
              stamp_d[{offset[2:0], 3'b000} +: 8] = byte_i;
            end else if (offset < CtrlBytes) begin
              seq_d[{offset[2:0], 3'b000} +: 8] = byte_i;
            end
          end
          if (frame_end) begin
            res_valid_o = 1'b1;
            res_o       = finish_other(type_q, len_q, stamp_d, seq_d);
          end
        end
      end
      default: begin
        phase_d = PhLenHi;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLenHi;
      len_q   <= '0;
      seen_q  <= '0;
      type_q  <= '0;
      stamp_q <= '0;
      seq_q   <= '0;
      skip_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      type_q  <= type_d;
      stamp_q <= stamp_d;
      seq_q   <= seq_d;
      skip_q  <= skip_d;
    end
  end

endmodule

[design/dfr_checker.sv]
module dfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  kind_i,
  input logic [7:0]  payload_byte_i,
  input logic        last_i,
  input logic [63:0] stamp_i,
  input logic [63:0] sequence_res_i
);
  import dfr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(payload_byte_i) && $stable(last_i) && $stable(stamp_i) &&
    $stable(sequence_res_i))
    else $error("result beat changed while stalled");

  // byte and last only on data beats
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KindData) |-> (payload_byte_i == 8'd0) && !last_i)
    else $error("data fields set on non-data result");

  // words only on complete ping or pong reports
  a_ctrl_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KindPing) && (kind_i != KindPong) |->
    (stamp_i == 64'd0) && (sequence_res_i == 64'd0))
    else $error("words set on non-control result");

  // with the result register empty nothing can hold up the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind length_prefixed_frame_deframer_core dfr_checker u_dfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (rx_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .payload_byte_i (res_o.payload_byte),
  .last_i         (res_o.last),
  .stamp_i        (res_o.stamp),
  .sequence_res_i (res_o.sequence_res)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dfr_pkg::*;

  localparam int HoldCycles = 60;
  localparam int HoldAfterBytes = 150;
  localparam int PhaseBytes = 100;
  localparam int NumLimits = 8;

  typedef enum logic [1:0] {
    PhLenHi,
    PhLenLo,
    PhType,
    PhBody
  } parse_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  dfr_in_if  rx_if ();
  dfr_out_if res_if ();

  length_prefixed_frame_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // parser mirror
  parse_phase_e p_phase = PhLenHi;
  logic [15:0]  p_len   = '0;
  logic [15:0]  p_seen  = '0;
  logic [7:0]   p_type  = '0;
  logic [63:0]  p_stamp = '0;
  logic [63:0]  p_seq   = '0;
  logic         p_skip  = 1'b0;
  logic [15:0]  p_limit = MaxLenReset;

  logic [7:0]  link_bytes_q [$];
  dfr_res_t    reports_due_q [$];
  int unsigned bytes_planned = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned kinds_seen [8];
  int unsigned idle_pct = 0;

  bit       rx_took = 1'b0;
  int       rx_gap = 0;
  int       res_gap = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  dfr_res_t got;
  dfr_res_t want;

  logic [7:0] directed_bytes [22] = '{
    8'h00, 8'h00,                      // length zero
    8'h00, 8'h02,                      // length just below header
    8'h00, 8'h03, 8'h00,               // empty data frame
    8'h00, 8'h03, 8'h01,               // ping with no payload
    8'h00, 8'h03, 8'hFF,               // unknown type, header only
    8'h00, 8'h05, 8'h00, 8'hFF, 8'h00, // two data bytes
    8'h00, 8'h04, 8'h02, 8'h80         // pong with one payload byte
  };

  function automatic dfr_res_t make_report(kind_e k, logic [7:0] b = 8'h00, logic l = 1'b0,
                                           logic [63:0] s = '0, logic [63:0] q = '0);
    dfr_res_t r;
    r.kind = k;
    r.payload_byte = b;
    r.last = l;
    r.stamp = s;
    r.sequence_res = q;
    return r;
  endfunction

  // end of a frame that is not data
  function automatic dfr_res_t ctrl_report();
    if (p_type == TypePing || p_type == TypePong) begin
      if (p_len - HeaderBytes >= CtrlBytes) begin
        return make_report((p_type == TypePing) ? KindPing : KindPong, 8'h00, 1'b0,
                           p_stamp, p_seq);
      end
      return make_report(KindShort);
    end
    return make_report(KindUnknown);
  endfunction

  task automatic parse_link_byte(input logic [7:0] b);
    logic [15:0] offs;
    logic        fin;
    case (p_phase)
      PhLenHi: begin
        p_len = {b, 8'h00};
        p_seen = 16'd1;
        p_phase = PhLenLo;
      end
      PhLenLo: begin
        p_len[7:0] = b;
        p_seen = 16'd2;
        if (p_len < HeaderBytes) begin
          // resync: next byte starts a new length
          p_phase = PhLenHi;
          p_seen = '0;
          reports_due_q.push_back(make_report(KindBadLen));
        end else if (p_len > p_limit) begin
          p_skip = 1'b1;
          p_phase = PhBody;
          reports_due_q.push_back(make_report(KindBadLen));
        end else begin
          p_skip = 1'b0;
          p_phase = PhType;
        end
      end
      PhType: begin
        p_type = b;
        p_seen = HeaderBytes;
        p_stamp = '0;
        p_seq = '0;
        if (p_len == HeaderBytes) begin
          p_phase = PhLenHi;
          if (p_type == TypeData) begin
            reports_due_q.push_back(make_report(KindEmpty));
          end else begin
            reports_due_q.push_back(ctrl_report());
          end
        end else begin
          p_phase = PhBody;
        end
      end
      default: begin
        offs = p_seen - HeaderBytes;
        p_seen = p_seen + 16'd1;
        fin = (p_seen >= p_len);
        if (fin) p_phase = PhLenHi;
        if (p_skip) begin
          if (fin) p_skip = 1'b0;
        end else if (p_type == TypeData) begin
          reports_due_q.push_back(make_report(KindData, b, fin));
        end else begin
          // words are little endian, bytes past the second word are dropped
          if (p_type == TypePing || p_type == TypePong) begin
            if (offs < WordBytes) begin
              p_stamp[offs * 8 +: 8] = b;
            end else if (offs < CtrlBytes) begin
              p_seq[(offs - WordBytes) * 8 +: 8] = b;
            end
          end
          if (fin) reports_due_q.push_back(ctrl_report());
        end
      end
    endcase
  endtask

  task automatic queue_frame(input logic [7:0] typ, input int plen);
    logic [15:0] len;
    len = 16'(plen + 3);
    link_bytes_q.push_back(len[15:8]);
    link_bytes_q.push_back(len[7:0]);
    link_bytes_q.push_back(typ);
    repeat (plen) link_bytes_q.push_back(8'($urandom_range(255)));
    bytes_planned += plen + 3;
  endtask

  // a length that is rejected, with the body a rejected but valid length still owns
  task automatic queue_span(input logic [15:0] len);
    link_bytes_q.push_back(len[15:8]);
    link_bytes_q.push_back(len[7:0]);
    bytes_planned += 2;
    if (len >= HeaderBytes) begin
      repeat (len - 2) link_bytes_q.push_back(8'($urandom_range(255)));
      bytes_planned += len - 2;
    end
  endtask

  task automatic queue_random_frame();
    int          pick;
    int unsigned over;
    pick = $urandom_range(99);
    over = p_limit + $urandom_range(1, 24);
    if (pick < 45 || (pick >= 84 && pick < 94 && over > 32'd64)) begin
      queue_frame(TypeData, $urandom_range(0, 24));
    end else if (pick < 70) begin
      queue_frame($urandom_range(1) ? TypePing : TypePong,
                  ($urandom_range(3) != 0) ? 16 : $urandom_range(0, 24));
    end else if (pick < 78) begin
      queue_frame(8'($urandom_range(3, 255)), $urandom_range(0, 8));
    end else if (pick < 84) begin
      queue_span(16'($urandom_range(0, 2)));
    end else if (pick < 94) begin
      queue_span(16'(over));
    end else begin
      // stray length, the parser eats what follows until it lines up again
      link_bytes_q.push_back(8'($urandom_range(1)));
      link_bytes_q.push_back(8'($urandom_range(255)));
      bytes_planned += 2;
    end
  endtask

  task automatic wait_idle();
    while (!(bytes_taken == bytes_planned && reports_due_q.size() == 0)) @(negedge clk_i);
    // bytes that give no result may still be in the pipe
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    p_limit = v;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_took || !rx_if.valid) begin
        if (rx_gap != 0) begin
          rx_if.valid <= 1'b0;
          rx_gap <= rx_gap - 1;
        end else if (link_bytes_q.size() != 0 && $urandom_range(399) < idle_pct) begin
          rx_if.valid <= 1'b0;
          rx_gap <= $urandom_range(7);
        end else if (link_bytes_q.size() != 0) begin
          rx_if.valid <= 1'b1;
          rx_if.rx_byte <= link_bytes_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the input side backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && bytes_taken >= HoldAfterBytes) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (res_gap != 0) begin
        res_gap <= res_gap - 1;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(399) < idle_pct) begin
        res_gap <= $urandom_range(7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // input beats feed the mirror, output beats are checked against it
  always @(posedge clk_i) begin
    rx_took <= rst_ni && rx_if.valid && rx_if.ready;
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      parse_link_byte(rx_if.rx_byte);
      bytes_taken++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.payload_byte = res_if.payload_byte;
      got.last = res_if.last;
      got.stamp = res_if.stamp;
      got.sequence_res = res_if.sequence_res;
      kinds_seen[got.kind]++;
      if (reports_due_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result kind %0d byte %h last %b stamp %h seq %h",
                 $time, got.kind, got.payload_byte, got.last, got.stamp, got.sequence_res);
      end else begin
        want = reports_due_q.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.last !== want.last || got.stamp !== want.stamp ||
            got.sequence_res !== want.sequence_res) begin
          mismatch_count++;
          $display("%0t: mismatch expected kind %0d byte %h last %b stamp %h seq %h",
                   $time, want.kind, want.payload_byte, want.last, want.stamp,
                   want.sequence_res);
          $display("%0t:          actual kind %0d byte %h last %b stamp %h seq %h",
                   $time, got.kind, got.payload_byte, got.last, got.stamp,
                   got.sequence_res);
        end
      end
    end
  end

  initial begin
    logic [15:0] limit_plan [NumLimits];
    int unsigned idle_plan [NumLimits];
    int unsigned target;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    foreach (kinds_seen[i]) kinds_seen[i] = 0;
    limit_plan = '{16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd19, 16'd0, 16'd1000, MaxLenReset};
    limit_plan[3] = 16'($urandom_range(4, 64));
    limit_plan[5] = 16'($urandom_range(20, 400));
    idle_plan = '{30, 0, 50, 20, 60, 0, 35, 0};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limit first, short directed frames
    idle_pct = 25;
    foreach (directed_bytes[i]) link_bytes_q.push_back(directed_bytes[i]);
    bytes_planned += $size(directed_bytes);
    wait_idle();

    for (int i = 0; i < NumLimits; i++) begin
      set_limit(limit_plan[i]);
      idle_pct = idle_plan[i];
      target = bytes_planned + PhaseBytes;
      while (bytes_planned < target) queue_random_frame();
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    mismatch_count += reports_due_q.size();
    $display("tb_top: %0d link bytes over %0d limit settings, %0d data, %0d ping, %0d pong",
             bytes_taken, NumLimits, kinds_seen[KindData], kinds_seen[KindPing],
             kinds_seen[KindPong]);
    $display("tb_top: %0d unknown, %0d bad length, %0d short control, %0d empty data",
             kinds_seen[KindUnknown], kinds_seen[KindBadLen], kinds_seen[KindShort],
             kinds_seen[KindEmpty]);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[filelist.f]
design/dfr_pkg.sv
design/dfr_if.sv
design/dfr_parser.sv
design/length_prefixed_frame_deframer_core.sv
design/dfr_checker.sv
tb/sv/tb_top.sv
